// ===== src/sefg_pkg.sv =====
// Package for the spectral energy frame gate: widths, reset values, register
// map and the running-sum bundle shared by the top level and the decision unit.
// No dependencies.
package sefg_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FFT_POINTS_DEF = 1024;
  localparam int FRAME_MAX     = 1024;
  localparam int POS_W         = $clog2(FRAME_MAX);
  localparam int LEN_W         = POS_W + 1;
  localparam int THR_W         = 17;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  // Sum of squares is never negative; the two plain sums carry a sign.
  localparam int SUMSQ_W = 2 * SAMPLE_BITS - 1 + POS_W;
  localparam int SUM_W   = SAMPLE_BITS + POS_W + 1;

  // Threshold is Q1.16; bring it onto the scale of the squared raw sums.
  localparam int THR_SHIFT = 2 * SAMPLE_BITS - 15;

  localparam logic [THR_W-1:0] THRESH_ONE   = THR_W'(65536);
  localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(58982);
  localparam logic [LEN_W-1:0] LEN_RESET    = LEN_W'(512);

  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_FRAME_LEN = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic        [SUMSQ_W-1:0] squares;
    logic signed [SUM_W-1:0]   plain;
    logic signed [SUM_W-1:0]   alternating;
  } sums_t;

endpackage

// ===== src/sefg_in_if.sv =====
// Input sample channel: valid/ready handshake carrying one signed sample word.
// Depends on sefg_pkg.
interface sefg_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [sefg_pkg::SAMPLE_BITS-1:0]   sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== src/sefg_out_if.sv =====
// Result channel: valid/ready handshake carrying the gated sample and flags.
// Depends on sefg_pkg.
interface sefg_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [sefg_pkg::SAMPLE_BITS-1:0]   sample_out;
  logic                                      out_valid;
  logic                                      gate_open;

  modport source (output valid, output sample_out, output out_valid, output gate_open,
                  input ready);
  modport sink   (input valid, input sample_out, input out_valid, input gate_open,
                  output ready);
endinterface

// ===== src/spectral_energy_frame_gate.sv =====
// Spectral energy frame gate, top level. An accepted sample passes stage 1 and
// stage 2 into the result register. Throughput: one word per cycle unless the
// output stalls; set by the frame store, which takes one read and one write
// at the same address each cycle (separate read and write ports, registered read).
// Reset: sync, active high; restores enable=1, threshold 58982, frame_len 512,
// clears sums, frame position, gate and stored-frame flag. No clearing pass.
// Depends on sefg_pkg, sefg_in_if, sefg_out_if, sefg_ram, sefg_decide.
module spectral_energy_frame_gate #(
  parameter int FFT_POINTS = sefg_pkg::FFT_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  sefg_in_if.sink                       samples,
  sefg_out_if.source                    gated,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sefg_pkg::ADDR_W-1:0]   paddr,
  input  logic [sefg_pkg::DATA_W-1:0]   pwdata,
  output logic [sefg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int SB      = sefg_pkg::SAMPLE_BITS;
  localparam int POS_W   = sefg_pkg::POS_W;
  localparam int LEN_W   = sefg_pkg::LEN_W;
  localparam int THR_W   = sefg_pkg::THR_W;
  localparam int SUMSQ_W = sefg_pkg::SUMSQ_W;
  localparam int SUM_W   = sefg_pkg::SUM_W;
  localparam int DATA_W  = sefg_pkg::DATA_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic             enable;
  logic [THR_W-1:0] gate_threshold;
  logic [LEN_W-1:0] frame_len;
  logic [POS_W-1:0] last_pos;       // effective frame length minus one

  logic              cfg_write;
  logic              restart;
  sefg_pkg::reg_idx_t cfg_idx;
  logic [THR_W-1:0]  thr_wr;
  logic [LEN_W-1:0]  len_wr;
  logic [POS_W-1:0]  last_wr;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = sefg_pkg::reg_idx_t'(paddr[3:2]);

  // Clamp threshold to one; map length zero to one and oversize to the store depth.
  always_comb begin
    thr_wr = pwdata[THR_W-1:0];
    if (thr_wr > sefg_pkg::THRESH_ONE) begin
      thr_wr = sefg_pkg::THRESH_ONE;
    end
    len_wr = pwdata[LEN_W-1:0];
    if (len_wr == '0) begin
      last_wr = '0;
    end else if (len_wr > LEN_W'(sefg_pkg::FRAME_MAX)) begin
      last_wr = POS_W'(sefg_pkg::FRAME_MAX - 1);
    end else begin
      last_wr = POS_W'(len_wr - LEN_W'(1));
    end
  end

  // Any write to a known register restarts framing.
  always_comb begin
    restart = 1'b0;
    prdata  = '0;
    unique case (cfg_idx)
      sefg_pkg::REG_ENABLE: begin
        restart = cfg_write;
        prdata  = DATA_W'(enable);
      end
      sefg_pkg::REG_THRESHOLD: begin
        restart = cfg_write;
        prdata  = DATA_W'(gate_threshold);
      end
      sefg_pkg::REG_FRAME_LEN: begin
        restart = cfg_write;
        prdata  = DATA_W'(frame_len);
      end
      default: begin
        restart = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b1;
      gate_threshold <= sefg_pkg::THRESH_RESET;
      frame_len      <= sefg_pkg::LEN_RESET;
      last_pos       <= POS_W'(sefg_pkg::LEN_RESET - LEN_W'(1));
    end else if (cfg_write) begin
      unique case (cfg_idx)
        sefg_pkg::REG_ENABLE:    enable <= pwdata[0];
        sefg_pkg::REG_THRESHOLD: gate_threshold <= thr_wr;
        sefg_pkg::REG_FRAME_LEN: begin
          frame_len <= len_wr;
          last_pos  <= last_wr;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: all stages move together whenever the result register
  // is empty or being taken, so a word can enter every cycle.
  // ---------------------------------------------------------------------------
  logic advance;
  logic accept;
  logic gate_step;     // accepted word with enable set goes through the framing path
  logic res_valid;

  assign advance       = !res_valid || gated.ready;
  assign samples.ready = advance;
  assign accept        = samples.valid && advance;
  assign gate_step     = accept && enable;

  // ---------------------------------------------------------------------------
  // Framing state and running sums (updated at the accept edge)
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]         frame_pos;
  logic [SUMSQ_W-1:0]       sum_squares;
  logic signed [SUM_W-1:0]  sum_plain;
  logic signed [SUM_W-1:0]  sum_alternating;
  logic                     frame_ready;

  logic signed [SB-1:0]     smp;
  logic signed [2*SB-1:0]   smp_sq;
  logic signed [SUM_W-1:0]  smp_ext;
  logic                     in_win;
  logic                     at_last;
  sefg_pkg::sums_t          sums_next;

  assign smp     = samples.sample_in;
  assign smp_sq  = smp * smp;
  assign smp_ext = SUM_W'(smp);
  // Only the part of the frame inside the transform window counts.
  assign in_win  = 32'(frame_pos) < 32'(FFT_POINTS);
  assign at_last = frame_pos == last_pos;

  always_comb begin
    sums_next.squares     = sum_squares;
    sums_next.plain       = sum_plain;
    sums_next.alternating = sum_alternating;
    if (in_win) begin
      sums_next.squares = sum_squares + SUMSQ_W'(smp_sq[2*SB-2:0]);
      sums_next.plain   = sum_plain + smp_ext;
      if (frame_pos[0]) begin
        sums_next.alternating = sum_alternating - smp_ext;
      end else begin
        sums_next.alternating = sum_alternating + smp_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      frame_pos       <= '0;
      sum_squares     <= '0;
      sum_plain       <= '0;
      sum_alternating <= '0;
      frame_ready     <= 1'b0;
    end else if (gate_step) begin
      if (at_last) begin
        frame_pos       <= '0;
        sum_squares     <= '0;
        sum_plain       <= '0;
        sum_alternating <= '0;
        frame_ready     <= 1'b1;
      end else begin
        frame_pos       <= frame_pos + POS_W'(1);
        sum_squares     <= sums_next.squares;
        sum_plain       <= sums_next.plain;
        sum_alternating <= sums_next.alternating;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame store: read the previous frame's word and overwrite it in the same cycle.
  // ---------------------------------------------------------------------------
  logic [SB-1:0] store_rdata;

  sefg_ram #(
    .WIDTH (SB),
    .DEPTH (sefg_pkg::FRAME_MAX)
  ) u_store (
    .clk   (clk),
    .we    (gate_step),
    .waddr (frame_pos),
    .wdata (smp),
    .re    (gate_step),
    .raddr (frame_pos),
    .rdata (store_rdata)
  );

  // ---------------------------------------------------------------------------
  // Energy decision for the frame that just closed
  // ---------------------------------------------------------------------------
  logic decide_open;

  sefg_decide #(
    .FFT_POINTS (FFT_POINTS)
  ) u_decide (
    .clk       (clk),
    .load      (gate_step && at_last),
    .advance   (advance),
    .sums      (sums_next),
    .threshold (gate_threshold),
    .greater   (decide_open)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: store read in flight
  // ---------------------------------------------------------------------------
  logic                 st1_valid;
  logic                 st1_bypass;
  logic                 st1_ready;
  logic                 st1_last;
  logic signed [SB-1:0] st1_smp;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (advance) begin
      st1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st1_bypass <= !enable;
      st1_ready  <= frame_ready;
      st1_last   <= at_last;
      st1_smp    <= smp;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: stored word in hand, decision squares in flight
  // ---------------------------------------------------------------------------
  logic                 st2_valid;
  logic                 st2_bypass;
  logic                 st2_ready;
  logic                 st2_last;
  logic signed [SB-1:0] st2_smp;

  always_ff @(posedge clk) begin
    if (rst) begin
      st2_valid <= 1'b0;
    end else if (advance) begin
      st2_valid <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st2_bypass <= st1_bypass;
      st2_ready  <= st1_ready;
      st2_last   <= st1_valid && !st1_bypass && st1_last;
      st2_smp    <= st1_bypass ? st1_smp : $signed(store_rdata);
    end
  end

  // ---------------------------------------------------------------------------
  // Gate of the frame being emitted. The closing word of a frame still uses
  // the old gate; the words after it see the new decision.
  // ---------------------------------------------------------------------------
  logic gate_state;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      gate_state <= 1'b0;
    end else if (advance && st2_valid && st2_last) begin
      gate_state <= decide_open;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic signed [SB-1:0] res_sample;
  logic                 res_out_valid;
  logic                 res_gate_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= st2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (st2_bypass) begin
        res_sample    <= st2_smp;
        res_out_valid <= 1'b1;
        res_gate_open <= 1'b1;
      end else begin
        // Drop the word to zero unless a stored frame exists and its gate is open.
        res_sample    <= (st2_ready && gate_state) ? st2_smp : '0;
        res_out_valid <= st2_ready;
        res_gate_open <= st2_ready && gate_state;
      end
    end
  end

  assign gated.valid      = res_valid;
  assign gated.sample_out = res_sample;
  assign gated.out_valid  = res_out_valid;
  assign gated.gate_open  = res_gate_open;

endmodule

// ===== src/sefg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered, read-first output.
// No dependencies.
module sefg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Same-address read and write return the old word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== src/sefg_decide.sv =====
// End-of-frame energy decision: snapshot of the three sums, one stage of squares
// and scaling, then one wide add and compare. Depends on sefg_pkg.
module sefg_decide #(
  parameter int FFT_POINTS = sefg_pkg::FFT_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          advance,
  input  sefg_pkg::sums_t               sums,
  input  logic [sefg_pkg::THR_W-1:0]    threshold,
  output logic                          greater
);

  localparam int NW     = $clog2(FFT_POINTS + 1);
  localparam int LHS_W  = sefg_pkg::SUMSQ_W + NW;
  localparam int PROD_W = 2 * sefg_pkg::SUM_W;
  localparam int SQ_W   = PROD_W - 2;
  localparam int THRT_W = sefg_pkg::THR_W + NW + sefg_pkg::THR_SHIFT;
  localparam int MAX_A  = (LHS_W > SQ_W + 1) ? LHS_W : SQ_W + 1;
  localparam int CMP_W  = ((MAX_A > THRT_W) ? MAX_A : THRT_W) + 1;

  sefg_pkg::sums_t snap;

  logic signed [PROD_W-1:0] prod_plain;
  logic signed [PROD_W-1:0] prod_alt;

  logic [LHS_W-1:0]  lhs;
  logic [SQ_W-1:0]   sq_plain;
  logic [SQ_W-1:0]   sq_alt;
  logic [THRT_W-1:0] thr_term;

  logic [CMP_W-1:0]  rhs_sum;

  assign prod_plain = snap.plain * snap.plain;
  assign prod_alt   = snap.alternating * snap.alternating;

  always_ff @(posedge clk) begin
    if (load) begin
      snap <= sums;
    end
    if (advance) begin
      lhs      <= LHS_W'(snap.squares) * LHS_W'(FFT_POINTS);
      sq_plain <= prod_plain[SQ_W-1:0];
      sq_alt   <= prod_alt[SQ_W-1:0];
      thr_term <= (THRT_W'(threshold) * THRT_W'(FFT_POINTS)) << sefg_pkg::THR_SHIFT;
    end
  end

  assign rhs_sum = CMP_W'(sq_plain) + CMP_W'(sq_alt) + CMP_W'(thr_term);
  assign greater = CMP_W'(lhs) > rhs_sum;

endmodule

// ===== tb/sv/spectral_energy_frame_gate_tb.sv =====
// Self-checking testbench for spectral_energy_frame_gate: streams sample words,
// rewrites the registers over APB between phases and checks every gated word.
// Depends on sefg_pkg, sefg_in_if, sefg_out_if and the gate's RTL.
module spectral_energy_frame_gate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS = sefg_pkg::SAMPLE_BITS;
  localparam int FRAME_MAX   = sefg_pkg::FRAME_MAX;
  localparam int DATA_W      = sefg_pkg::DATA_W;
  localparam int ADDR_W      = sefg_pkg::ADDR_W;
  localparam int THR_W       = sefg_pkg::THR_W;
  localparam int LEN_W       = sefg_pkg::LEN_W;

  localparam int FFT_N       = sefg_pkg::FFT_POINTS_DEF;
  localparam int WORD_TOTAL  = 1950;
  localparam int CALM_TAIL   = 150;
  localparam int SETTLE      = 4;   // result register sits behind the stage registers
  localparam int NO_GAPS     = 1000;
  // Index past the last register: writes there must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          out_valid;
    logic                          gate_open;
  } gated_word_t;

  typedef enum logic {ROW_WORD, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [1:0]        reg_sel;
    logic [DATA_W-1:0] data;
    logic              typed;   // take the expected word from this row
    gated_word_t       want;
  } plan_row_t;

  // Directed opening: first frame after reset, bypass at the sample extremes,
  // zero length taken as one, threshold zero and saturated, two-word frames of
  // alternating full-scale words, and a write to an unused index.
  localparam plan_row_t PLAN [32] = '{
    '{ROW_WORD,  2'd0,          32'h0000_7FFF, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_8000, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WRITE, sefg_pkg::REG_ENABLE,    32'h0000_0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_7FFF, 1'b1, '{16'h7FFF, 1'b1, 1'b1}},
    '{ROW_WORD,  2'd0,          32'h0000_8000, 1'b1, '{16'h8000, 1'b1, 1'b1}},
    '{ROW_WORD,  2'd0,          32'h0000_0000, 1'b1, '{16'h0000, 1'b1, 1'b1}},
    '{ROW_WORD,  2'd0,          32'h0000_FFFF, 1'b1, '{16'hFFFF, 1'b1, 1'b1}},
    '{ROW_WRITE, sefg_pkg::REG_FRAME_LEN, 32'h0000_0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WRITE, sefg_pkg::REG_ENABLE,    32'h0000_0001, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_7FFF, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_8000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WRITE, sefg_pkg::REG_THRESHOLD, 32'h0000_0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_1234, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_8000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_0001, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WRITE, sefg_pkg::REG_THRESHOLD, 32'h0001_FFFF, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WRITE, sefg_pkg::REG_FRAME_LEN, 32'h0000_0002, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_7FFF, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_8000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_7FFF, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_8000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WRITE, sefg_pkg::REG_THRESHOLD, 32'h0000_0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_7FFF, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_8000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_7FFF, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_8000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WRITE, REG_SPARE,     32'hFFFF_FFFF, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_5555, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_AAAA, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
    '{ROW_WORD,  2'd0,          32'h0000_0000, 1'b0, '{16'h0000, 1'b0, 1'b0}}
  };

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  sefg_in_if  samples_if ();
  sefg_out_if gated_if ();

  spectral_energy_frame_gate u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .gated   (gated_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Gate model: register copies and framing state, updated as words go in.
  logic signed [SAMPLE_BITS-1:0] frame_copy [FRAME_MAX];
  int unsigned pos_now;
  longint      sq_acc;
  longint      plain_acc;
  longint      alt_acc;
  bit          gate_now;
  bit          have_frame;
  bit          enable_now;
  int unsigned thr_now;
  int unsigned len_now;

  gated_word_t gated_due [$];   // gated words still owed by the block

  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned errors;
  int unsigned settings;
  int unsigned bypassed;
  int unsigned loud_frames;
  int unsigned quiet_frames;
  bit          calm;   // tail of the run: no idling on either side

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous ceiling: the slowest legal run needs well under a millisecond.
  initial begin
    #8ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void restart_framing();
    pos_now    = 0;
    sq_acc     = 0;
    plain_acc  = 0;
    alt_acc    = 0;
    gate_now   = 1'b0;
    have_frame = 1'b0;
  endfunction

  // Mirror one register write; any known index restarts the framing.
  function automatic void apply_reg(logic [1:0] sel, logic [DATA_W-1:0] data);
    case (sel)
      sefg_pkg::REG_ENABLE: begin
        enable_now = data[0];
      end
      sefg_pkg::REG_THRESHOLD: begin
        thr_now = 32'((data[THR_W-1:0] > sefg_pkg::THRESH_ONE) ?
                      sefg_pkg::THRESH_ONE : data[THR_W-1:0]);
      end
      sefg_pkg::REG_FRAME_LEN: begin
        len_now = 32'(data[LEN_W-1:0]);
      end
      default: begin
        return;
      end
    endcase
    restart_framing();
  endfunction

  function automatic int unsigned frame_span();
    if (len_now == 0) return 1;
    if (len_now > FRAME_MAX) return FRAME_MAX;
    return len_now;
  endfunction

  // Band energy against threshold, exact: N*S2 > S1^2 + SA^2 + T*N*2^17.
  function automatic bit frame_loud();
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [127:0] mag_plain;
    logic [127:0] mag_alt;
    mag_plain = 128'(plain_acc < 0 ? -plain_acc : plain_acc);
    mag_alt   = 128'(alt_acc < 0 ? -alt_acc : alt_acc);
    lhs = 128'(FFT_N) * 128'(sq_acc);
    rhs = mag_plain * mag_plain + mag_alt * mag_alt
        + ((128'(thr_now) * 128'(FFT_N)) << (2 * SAMPLE_BITS - 15));
    return lhs > rhs;
  endfunction

  // Bypass returns the sample; else emit the word at this position of the
  // stored frame, then fold the sample into the store and three running sums.
  function automatic gated_word_t gate_step(logic signed [SAMPLE_BITS-1:0] s);
    gated_word_t w;
    int unsigned p;
    if (!enable_now) begin
      w.sample_out = s;
      w.out_valid  = 1'b1;
      w.gate_open  = 1'b1;
      bypassed++;
      return w;
    end
    p = pos_now % FRAME_MAX;
    w.sample_out = (have_frame && gate_now) ? frame_copy[p] : '0;
    w.out_valid  = have_frame;
    w.gate_open  = have_frame && gate_now;
    frame_copy[p] = s;
    if (p < FFT_N) begin
      sq_acc    += longint'(s) * longint'(s);
      plain_acc += longint'(s);
      alt_acc   += (p % 2 == 1) ? -longint'(s) : longint'(s);
    end
    if (p + 1 >= frame_span()) begin
      gate_now   = frame_loud();
      have_frame = 1'b1;
      if (gate_now) loud_frames++;
      else quiet_frames++;
      pos_now   = 0;
      sq_acc    = 0;
      plain_acc = 0;
      alt_acc   = 0;
    end else begin
      pos_now = p + 1;
    end
    return w;
  endfunction

  task automatic report_miss(string field, int got, int want_v);
    $display("MISS %s at gated word %0d: got %0d, want %0d",
             field, words_checked, got, want_v);
    errors++;
  endtask

  // Offer one sample word and hold it until taken, then log what it owes.
  task automatic put_word(logic signed [SAMPLE_BITS-1:0] s, logic typed,
                          gated_word_t want);
    gated_word_t predicted;
    samples_if.valid     <= 1'b1;
    samples_if.sample_in <= s;
    do @(posedge clk); while (!samples_if.ready);
    predicted = gate_step(s);
    gated_due.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  // Drop valid for a random burst now and then, but never in the calm tail.
  task automatic rest_sender(int unsigned gap_odds);
    if (!calm && $urandom_range(0, gap_odds) == 0) begin
      samples_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Drain every owed word, let the pipeline settle, then do one APB write.
  task automatic write_reg(logic [1:0] sel, logic [DATA_W-1:0] data);
    samples_if.valid <= 1'b0;
    while (gated_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({sel, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_reg(sel, data);
    settings++;
  endtask

  // Receiver stalls: random bursts of back-pressure, none in the calm tail.
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        gated_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      gated_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // Check each accepted gated word against the oldest one owed.
  always @(posedge clk) begin
    gated_word_t want;
    if (!rst && gated_if.valid && gated_if.ready) begin
      if (gated_due.size() == 0) begin
        report_miss("unexpected word", int'(gated_if.sample_out), 0);
      end else begin
        want = gated_due.pop_front();
        if (gated_if.sample_out !== want.sample_out)
          report_miss("sample_out", int'(gated_if.sample_out), int'(want.sample_out));
        if (gated_if.out_valid !== want.out_valid)
          report_miss("out_valid", int'(gated_if.out_valid), int'(want.out_valid));
        if (gated_if.gate_open !== want.gate_open)
          report_miss("gate_open", int'(gated_if.gate_open), int'(want.gate_open));
      end
      words_checked++;
    end
  end

  initial begin
    int unsigned len_eff;
    int unsigned n_words;
    int unsigned amp;
    int unsigned gap_odds;
    logic [DATA_W-1:0] data;
    logic signed [SAMPLE_BITS-1:0] s;
    bit big_done;

    // Hold every input at a known value from time zero.
    rst                  <= 1'b1;
    samples_if.valid     <= 1'b0;
    samples_if.sample_in <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    calm      = 1'b0;
    big_done  = 1'b0;
    enable_now = 1'b1;
    thr_now    = 32'(sefg_pkg::THRESH_RESET);
    len_now    = 32'(sefg_pkg::LEN_RESET);
    restart_framing();
    foreach (frame_copy[i]) frame_copy[i] = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed opening, walked row by row.
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        write_reg(PLAN[i].reg_sel, PLAN[i].data);
      end else begin
        put_word(PLAN[i].data[SAMPLE_BITS-1:0], PLAN[i].typed, PLAN[i].want);
      end
    end

    // Random phases: new settings, then whole frames plus a partial one, or a bypass run.
    while (words_sent < WORD_TOTAL) begin
      if (!big_done && words_sent > 700) begin
        // One long phase at the largest frame, with oversize lengths clamped.
        data = $urandom;
        data[0] = 1'b1;
        write_reg(sefg_pkg::REG_ENABLE, data);
        data = $urandom;
        data[LEN_W-1:0] = LEN_W'($urandom_range(0, 1) ? FRAME_MAX
                                                      : $urandom_range(1025, 2047));
        write_reg(sefg_pkg::REG_FRAME_LEN, data);
        data = $urandom;
        data[THR_W-1:0] = THR_W'($urandom_range(0, 4096));
        write_reg(sefg_pkg::REG_THRESHOLD, data);
        big_done = 1'b1;
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          data = $urandom;
          data[0] = ($urandom_range(0, 5) != 0);
          write_reg(sefg_pkg::REG_ENABLE, data);
        end
        if ($urandom_range(0, 1) == 0) begin
          data = $urandom;
          case ($urandom_range(0, 9))
            0:       data[THR_W-1:0] = '0;
            1:       data[THR_W-1:0] = THR_W'($urandom_range(65536, 131071));
            default: data[THR_W-1:0] = THR_W'($urandom_range(0, 65536) >>
                                              $urandom_range(0, 8));
          endcase
          write_reg(sefg_pkg::REG_THRESHOLD, data);
        end
        if ($urandom_range(0, 1) == 0) begin
          data = $urandom;
          data[LEN_W-1:0] = LEN_W'(($urandom_range(0, 15) == 0) ? 0
                                                                : $urandom_range(1, 24));
          write_reg(sefg_pkg::REG_FRAME_LEN, data);
        end
        if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, $urandom);
      end

      len_eff = frame_span();
      if (!enable_now) n_words = $urandom_range(4, 40);
      else if (len_eff > 64) n_words = len_eff + $urandom_range(16, 48);
      else n_words = len_eff * $urandom_range(2, 4) + $urandom_range(0, len_eff);
      if (words_sent + n_words > WORD_TOTAL) n_words = WORD_TOTAL - words_sent;

      amp      = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 14) : $urandom_range(0, 3);
      gap_odds = ($urandom_range(0, 2) == 0) ? NO_GAPS : $urandom_range(2, 6);

      repeat (n_words) begin
        rest_sender(gap_odds);
        if ($urandom_range(0, 15) == 0) s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        else s = $signed(16'($urandom)) >>> amp;
        put_word(s, 1'b0, '0);
        calm = (words_sent >= WORD_TOTAL - CALM_TAIL);
      end
    end

    // Drain, then let the pipeline run on so that stray words show.
    samples_if.valid <= 1'b0;
    while (gated_due.size() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);

    $display("Ran %0d sample words through %0d register writes, %0d in bypass.",
             words_sent, settings, bypassed);
    $display("Judged %0d frames loud and %0d quiet; checked %0d gated words.",
             loud_frames, quiet_frames, words_checked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== spectral_energy_frame_gate.f =====
src/sefg_pkg.sv
src/sefg_in_if.sv
src/sefg_out_if.sv
src/sefg_ram.sv
src/sefg_decide.sv
src/spectral_energy_frame_gate.sv
tb/sv/spectral_energy_frame_gate_tb.sv
